[sv/hrp_pkg.sv]
`timescale 1ns / 1ps

package hrp_pkg;

    typedef enum logic [3:0] {
        PH_METHOD = 4'd0,
        PH_SLASH  = 4'd1,
        PH_URI    = 4'd2,
        PH_HEX1   = 4'd3,
        PH_HEX2   = 4'd4,
        PH_HTTP   = 4'd5,
        PH_VMAJ   = 4'd6,
        PH_VDOT   = 4'd7,
        PH_VMIN   = 4'd8,
        PH_CR     = 4'd9,
        PH_LF     = 4'd10,
        PH_LINE   = 4'd11,
        PH_KEY    = 4'd12,
        PH_DELIM  = 4'd13,
        PH_VALUE  = 4'd14
    } phase_t;

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_URI     = 3'd1,
        KIND_VER     = 3'd2,
        KIND_KEY     = 3'd3,
        KIND_VALUE   = 3'd4,
        KIND_HDR_END = 3'd5,
        KIND_OK      = 3'd6,
        KIND_ERR     = 3'd7
    } kind_t;

    // One result beat as it sits in the output queue.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
    } result_t;

    // Everything one input byte produces: zero, one or two results.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    localparam int HTTP_TAG_LEN = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_uri_sym(input logic [7:0] c);
        return c == CH_DOT || c == CH_SLASH || c == 8'h3F || c == 8'h26 ||
               c == 8'h3D || c == 8'h5F || c == 8'h2D;
    endfunction

    function automatic logic is_key_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == 8'h2D;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // Expected characters of "HTTP/".
    function automatic logic [7:0] http_tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[sv/http_request_head_parser_top.sv]
`timescale 1ns / 1ps

// Channel   Valid          Stall          Payload
// input     byte_valid     byte_stall     in_byte[7:0], final_byte
// output    result_valid   result_stall   kind[2:0], data[7:0], last_of_run
//
// One request byte is taken per clock while byte_stall is low. Its results
// reach the output queue at the same edge and can leave from the next cycle,
// one beat per clock while result_stall is low. A final byte may produce two
// results; the queue absorbs the extra beat. byte_stall rises only while the
// four-entry queue has fewer than two free entries, so it depends on registered
// state alone. Reset returns the parser to the method phase and empties the queue.
module http_request_head_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] kind,
    output logic [7:0] data,
    output logic       last_of_run
);

    logic                           step;
    logic                           pop;
    hrp_pkg::step_out_t             res;
    hrp_pkg::result_t               head;
    logic [hrp_pkg::QLEVEL_W-1:0]   level;

    assign byte_stall   = level > hrp_pkg::QLEVEL_W'(hrp_pkg::QUEUE_DEPTH - 2);
    assign step         = byte_valid && !byte_stall;
    assign result_valid = level != '0;
    assign pop          = result_valid && !result_stall;

    hrp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .res        (res)
    );

    hrp_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wr    (res),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    assign kind        = head.kind;
    assign data        = head.data;
    assign last_of_run = head.last;

    // Two result beats must always fit when a byte is taken.
    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> level <= hrp_pkg::QLEVEL_W'(hrp_pkg::QUEUE_DEPTH - 2))
        else $error("byte taken without room for two results");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= hrp_pkg::QLEVEL_W'(hrp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // Every final byte ends its request with at least one result beat.
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && final_byte) |=> result_valid)
        else $error("final byte produced no result");

endmodule

[sv/hrp_parser.sv]
`timescale 1ns / 1ps

module hrp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              final_byte,
    output hrp_pkg::step_out_t res
);

    hrp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      sub_count_reg, sub_count_next;
    logic [3:0]      hex_high_reg, hex_high_next;
    logic            key_seen_reg, key_seen_next;
    logic            blank_reg, blank_next;
    logic            failed_reg, failed_next;

    logic            bad;
    logic            dv;
    hrp_pkg::kind_t  dk;
    logic [7:0]      dd;
    logic [4:0]      hv;
    hrp_pkg::kind_t  fin_kind;

    assign hv = hrp_pkg::hex_val(in_byte);

    always_comb
    begin
        phase_next     = phase_reg;
        sub_count_next = sub_count_reg;
        hex_high_next  = hex_high_reg;
        key_seen_next  = key_seen_reg;
        blank_next     = blank_reg;
        failed_next    = failed_reg;
        bad            = 1'b0;
        dv             = 1'b0;
        dk             = hrp_pkg::KIND_METHOD;
        dd             = 8'h00;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                hrp_pkg::PH_METHOD:
                begin
                    if (hrp_pkg::is_letter(in_byte))
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_METHOD;
                        dd = in_byte;
                    end
                    else if (in_byte == hrp_pkg::CH_SPACE)
                        phase_next = hrp_pkg::PH_SLASH;
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_SLASH:
                begin
                    if (in_byte == hrp_pkg::CH_SLASH)
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_URI;
                        dd = in_byte;
                        phase_next = hrp_pkg::PH_URI;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_URI:
                begin
                    if (hrp_pkg::is_letter(in_byte) || hrp_pkg::is_digit(in_byte) ||
                        hrp_pkg::is_uri_sym(in_byte))
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_URI;
                        dd = in_byte;
                    end
                    else if (in_byte == hrp_pkg::CH_PLUS)
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_URI;
                        dd = hrp_pkg::CH_SPACE;
                    end
                    else if (in_byte == hrp_pkg::CH_PERCENT)
                        phase_next = hrp_pkg::PH_HEX1;
                    else if (in_byte == hrp_pkg::CH_SPACE)
                    begin
                        phase_next     = hrp_pkg::PH_HTTP;
                        sub_count_next = 3'd0;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_HEX1:
                begin
                    if (!hv[4])
                        bad = 1'b1;
                    else
                    begin
                        hex_high_next = hv[3:0];
                        phase_next    = hrp_pkg::PH_HEX2;
                    end
                end
                hrp_pkg::PH_HEX2:
                begin
                    if (!hv[4])
                        bad = 1'b1;
                    else
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_URI;
                        dd = {hex_high_reg, hv[3:0]};
                        phase_next = hrp_pkg::PH_URI;
                    end
                end
                hrp_pkg::PH_HTTP:
                begin
                    if (sub_count_reg < 3'(hrp_pkg::HTTP_TAG_LEN) &&
                        in_byte == hrp_pkg::http_tag_char(sub_count_reg))
                    begin
                        if (sub_count_reg == 3'(hrp_pkg::HTTP_TAG_LEN - 1))
                        begin
                            sub_count_next = 3'd0;
                            phase_next     = hrp_pkg::PH_VMAJ;
                        end
                        else
                            sub_count_next = sub_count_reg + 3'd1;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_VMAJ:
                begin
                    if (hrp_pkg::is_digit(in_byte))
                        phase_next = hrp_pkg::PH_VDOT;
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_VDOT:
                begin
                    if (in_byte == hrp_pkg::CH_DOT)
                        phase_next = hrp_pkg::PH_VMIN;
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_VMIN:
                begin
                    if (hrp_pkg::is_digit(in_byte))
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_VER;
                        dd = in_byte;
                        phase_next = hrp_pkg::PH_CR;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_CR:
                begin
                    if (in_byte == hrp_pkg::CH_CR)
                    begin
                        blank_next = 1'b0;
                        phase_next = hrp_pkg::PH_LF;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_LF:
                begin
                    // On an LF, a request may only end if that LF closes a blank line.
                    if (in_byte != hrp_pkg::CH_LF || (final_byte && !blank_reg))
                        bad = 1'b1;
                    else
                        phase_next = hrp_pkg::PH_LINE;
                end
                hrp_pkg::PH_LINE:
                begin
                    if (in_byte == hrp_pkg::CH_CR)
                    begin
                        blank_next = 1'b1;
                        phase_next = hrp_pkg::PH_LF;
                    end
                    else if (hrp_pkg::is_key_char(in_byte))
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_KEY;
                        dd = in_byte;
                        key_seen_next = 1'b1;
                        phase_next    = hrp_pkg::PH_KEY;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_KEY:
                begin
                    if (hrp_pkg::is_key_char(in_byte))
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_KEY;
                        dd = in_byte;
                        key_seen_next = 1'b1;
                    end
                    else if (in_byte == hrp_pkg::CH_COLON && key_seen_reg)
                    begin
                        key_seen_next = 1'b0;
                        phase_next    = hrp_pkg::PH_DELIM;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_DELIM:
                begin
                    if (in_byte == hrp_pkg::CH_SPACE)
                    begin
                        sub_count_next = 3'd0;
                        phase_next     = hrp_pkg::PH_VALUE;
                    end
                    else
                        bad = 1'b1;
                end
                hrp_pkg::PH_VALUE:
                begin
                    // The first value byte is taken as data even when it is a CR.
                    if (sub_count_reg != 3'd0 && in_byte == hrp_pkg::CH_CR)
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_HDR_END;
                        dd = 8'h00;
                        sub_count_next = 3'd0;
                        blank_next     = 1'b0;
                        phase_next     = hrp_pkg::PH_LF;
                    end
                    else
                    begin
                        dv = 1'b1;
                        dk = hrp_pkg::KIND_VALUE;
                        dd = in_byte;
                        sub_count_next = 3'd1;
                    end
                end
                default:
                    bad = 1'b1;
            endcase
            if (bad)
                failed_next = 1'b1;
        end

        if (final_byte)
        begin
            phase_next     = hrp_pkg::PH_METHOD;
            sub_count_next = 3'd0;
            hex_high_next  = 4'd0;
            key_seen_next  = 1'b0;
            blank_next     = 1'b0;
            failed_next    = 1'b0;
        end
    end

    assign fin_kind = failed_reg ? hrp_pkg::KIND_ERR : hrp_pkg::KIND_OK;

    always_comb
    begin
        res.count = 2'd0;
        res.r0    = '{kind: hrp_pkg::KIND_ERR, data: 8'h00, last: 1'b1};
        res.r1    = '{kind: fin_kind, data: 8'h00, last: 1'b1};
        if (bad)
            res.count = 2'd1;
        else if (dv)
        begin
            res.r0 = '{kind: dk, data: dd, last: !final_byte};
            res.count = final_byte ? 2'd2 : 2'd1;
        end
        else if (final_byte)
        begin
            res.r0    = '{kind: fin_kind, data: 8'h00, last: 1'b1};
            res.count = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hrp_pkg::PH_METHOD;
            sub_count_reg <= 3'd0;
            hex_high_reg  <= 4'd0;
            key_seen_reg  <= 1'b0;
            blank_reg     <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            sub_count_reg <= sub_count_next;
            hex_high_reg  <= hex_high_next;
            key_seen_reg  <= key_seen_next;
            blank_reg     <= blank_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

[sv/hrp_result_queue.sv]
`timescale 1ns / 1ps

module hrp_result_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  hrp_pkg::step_out_t             wr,
    input  logic                           pop,
    output hrp_pkg::result_t               head,
    output logic [hrp_pkg::QLEVEL_W-1:0]   level
);

    hrp_pkg::result_t                mem [hrp_pkg::QUEUE_DEPTH];
    logic [hrp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hrp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hrp_pkg::QLEVEL_W-1:0]    level_reg, level_next;
    logic [1:0]                      push_n;

    assign push_n = push ? wr.count : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + hrp_pkg::QPTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + hrp_pkg::QPTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + hrp_pkg::QLEVEL_W'(push_n) -
                      hrp_pkg::QLEVEL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= wr.r0;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + hrp_pkg::QPTR_W'(1)] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign level = level_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int BYTE_TARGET = 850;
    localparam logic [39:0] HTTP_WORD = "HTTP/";

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] in_byte;
    logic       final_byte;
    logic       result_valid;
    logic       result_stall;
    logic [2:0] kind;
    logic [7:0] data;
    logic       last_of_run;

    // Parser state as the testbench tracks it.
    hrp_pkg::phase_t pstate;
    logic [2:0] tag_idx;
    logic [3:0] hi_nib;
    logic       key_started;
    logic       value_started;
    logic       blank_line;
    logic       in_error;

    hrp_pkg::result_t pending_results[$];
    int unsigned fail_count = 0;
    int unsigned live_bytes = 0;
    int unsigned src_max_gap = 0;
    int unsigned sink_max_gap = 0;

    http_request_head_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data         (data),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic chr_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic chr_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic chr_token(input logic [7:0] c);
        return chr_alpha(c) || chr_num(c) || c == "-";
    endfunction

    function automatic logic chr_path(input logic [7:0] c);
        return chr_alpha(c) || chr_num(c) || c == hrp_pkg::CH_DOT ||
               c == hrp_pkg::CH_SLASH || c == "?" ||
               c == "&" || c == "=" || c == "_" || c == "-";
    endfunction

    // Bit 4 says the byte is a hex digit; the low nibble is its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic hrp_pkg::result_t beat(input hrp_pkg::kind_t k, input logic [7:0] d);
        hrp_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void reset_parser();
        pstate = hrp_pkg::PH_METHOD;
        tag_idx = 3'd0;
        hi_nib = 4'd0;
        key_started = 1'b0;
        value_started = 1'b0;
        blank_line = 1'b0;
        in_error = 1'b0;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic [7:0] pick_char(input string pool);
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic int unsigned pick_gap_limit();
        case ($urandom_range(2))
            0: return 0;
            1: return 3;
            default: return 17;
        endcase
    endfunction

    // Works out the beats that one accepted request byte must produce.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        hrp_pkg::result_t beats[$];
        logic       bad;
        logic [4:0] hx;
        bad = 1'b0;
        hx = hex_nibble(b);
        if (!in_error)
        begin
            case (pstate)
                hrp_pkg::PH_METHOD:
                    if (chr_alpha(b))
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_METHOD, b));
                    else if (b == hrp_pkg::CH_SPACE)
                        pstate = hrp_pkg::PH_SLASH;
                    else
                        bad = 1'b1;
                hrp_pkg::PH_SLASH:
                    if (b == hrp_pkg::CH_SLASH)
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_URI, b));
                        pstate = hrp_pkg::PH_URI;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_URI:
                    if (chr_path(b))
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_URI, b));
                    else if (b == hrp_pkg::CH_PLUS)
                        beats.insert(beats.size(),
                                     beat(hrp_pkg::KIND_URI, hrp_pkg::CH_SPACE));
                    else if (b == hrp_pkg::CH_PERCENT)
                        pstate = hrp_pkg::PH_HEX1;
                    else if (b == hrp_pkg::CH_SPACE)
                    begin
                        tag_idx = 3'd0;
                        pstate = hrp_pkg::PH_HTTP;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_HEX1:
                    if (hx[4])
                    begin
                        hi_nib = hx[3:0];
                        pstate = hrp_pkg::PH_HEX2;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_HEX2:
                    if (hx[4])
                    begin
                        beats.insert(beats.size(),
                                     beat(hrp_pkg::KIND_URI, {hi_nib, hx[3:0]}));
                        pstate = hrp_pkg::PH_URI;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_HTTP:
                    if (b == HTTP_WORD[39 - 8 * tag_idx -: 8])
                    begin
                        if (tag_idx == 3'd4)
                        begin
                            tag_idx = 3'd0;
                            pstate = hrp_pkg::PH_VMAJ;
                        end
                        else
                            tag_idx = tag_idx + 3'd1;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_VMAJ:
                    if (chr_num(b))
                        pstate = hrp_pkg::PH_VDOT;
                    else
                        bad = 1'b1;
                hrp_pkg::PH_VDOT:
                    if (b == hrp_pkg::CH_DOT)
                        pstate = hrp_pkg::PH_VMIN;
                    else
                        bad = 1'b1;
                hrp_pkg::PH_VMIN:
                    if (chr_num(b))
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_VER, b));
                        pstate = hrp_pkg::PH_CR;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_CR:
                    if (b == hrp_pkg::CH_CR)
                    begin
                        blank_line = 1'b0;
                        pstate = hrp_pkg::PH_LF;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_LF:
                    // A request may not stop on the line feed of a header line.
                    if (b != hrp_pkg::CH_LF || (fin && !blank_line))
                        bad = 1'b1;
                    else
                        pstate = hrp_pkg::PH_LINE;
                hrp_pkg::PH_LINE:
                    if (b == hrp_pkg::CH_CR)
                    begin
                        blank_line = 1'b1;
                        pstate = hrp_pkg::PH_LF;
                    end
                    else if (chr_token(b))
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_KEY, b));
                        key_started = 1'b1;
                        pstate = hrp_pkg::PH_KEY;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_KEY:
                    if (chr_token(b))
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_KEY, b));
                        key_started = 1'b1;
                    end
                    else if (b == hrp_pkg::CH_COLON && key_started)
                    begin
                        key_started = 1'b0;
                        pstate = hrp_pkg::PH_DELIM;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_DELIM:
                    if (b == hrp_pkg::CH_SPACE)
                    begin
                        value_started = 1'b0;
                        pstate = hrp_pkg::PH_VALUE;
                    end
                    else
                        bad = 1'b1;
                hrp_pkg::PH_VALUE:
                    // The first value byte is taken as data even when it is a CR.
                    if (value_started && b == hrp_pkg::CH_CR)
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_HDR_END, 8'h00));
                        value_started = 1'b0;
                        blank_line = 1'b0;
                        pstate = hrp_pkg::PH_LF;
                    end
                    else
                    begin
                        beats.insert(beats.size(), beat(hrp_pkg::KIND_VALUE, b));
                        value_started = 1'b1;
                    end
                default:
                    bad = 1'b1;
            endcase
            if (bad)
            begin
                in_error = 1'b1;
                beats.delete();
                beats.insert(beats.size(), beat(hrp_pkg::KIND_ERR, 8'h00));
            end
        end
        if (fin)
        begin
            if (!bad)
            begin
                if (in_error)
                    beats.insert(beats.size(), beat(hrp_pkg::KIND_ERR, 8'h00));
                else
                    beats.insert(beats.size(), beat(hrp_pkg::KIND_OK, 8'h00));
            end
            reset_parser();
        end
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            pending_results.insert(pending_results.size(), beats[i]);
        live_bytes++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        gap = $urandom_range(src_max_gap);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (byte_stall);
        parse_byte(b, fin);
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i])
            push_byte(q[i], i == q.size() - 1);
    endtask

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.insert(q.size(), s[i]);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        add_text(q, s);
        send_bytes(q);
    endtask

    // Empty method, then a minimal request closed by a blank line.
    task automatic test_request_line();
        src_max_gap = 0;
        sink_max_gap = 0;
        send_text(" / HTTP/1.0\r\n\r\n");
    endtask

    // URI decoding, a value that starts with CR, a header after the blank line,
    // and an illegal stop on the line feed of that header.
    task automatic test_header_block();
        src_max_gap = 17;
        sink_max_gap = 3;
        send_text("Pz /%4a%F0+.?&=_-9 HTTP/2.3\r\nk: \rv\r\n\r\nA-9: x\r\n");
    endtask

    task automatic test_violations();
        src_max_gap = 3;
        sink_max_gap = 17;
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        send_text("a");
        send_text("GE");
        send_text("G /%4g");
        send_text("G /%zz");
        send_text("G /a%");
        send_text("G /b HTTQ/");
    endtask

    task automatic test_random_requests();
        logic [7:0]  req[$];
        logic [7:0]  v;
        int unsigned hcount;
        while (live_bytes < BYTE_TARGET)
        begin
            src_max_gap = pick_gap_limit();
            sink_max_gap = pick_gap_limit();
            req.delete();
            repeat ($urandom_range(4))
                req.insert(req.size(), pick_char("abcxyzABCXYZ"));
            add_text(req, " /");
            repeat ($urandom_range(6))
            begin
                case ($urandom_range(9))
                    7: req.insert(req.size(), hrp_pkg::CH_PLUS);
                    8, 9:
                    begin
                        req.insert(req.size(), hrp_pkg::CH_PERCENT);
                        req.insert(req.size(), pick_char("0123456789abcdefABCDEF"));
                        req.insert(req.size(), pick_char("0123456789abcdefABCDEF"));
                    end
                    default: req.insert(req.size(), pick_char("aqzAQZ059./?&=_-"));
                endcase
            end
            add_text(req, " HTTP/");
            req.insert(req.size(), pick_char("0123456789"));
            req.insert(req.size(), hrp_pkg::CH_DOT);
            req.insert(req.size(), pick_char("0123456789"));
            add_text(req, "\r\n");
            hcount = $urandom_range(3);
            for (int h = 0; h <= hcount; h++)
            begin
                // The last pass closes the head with a blank line, sometimes
                // followed by one more header line.
                if (h == hcount)
                begin
                    add_text(req, "\r\n");
                    if ($urandom_range(3) != 0)
                        break;
                end
                repeat ($urandom_range(1, 4))
                    req.insert(req.size(), pick_char("aqzAQZ059-"));
                add_text(req, ": ");
                req.insert(req.size(), 8'($urandom_range(255)));
                repeat ($urandom_range(4))
                begin
                    v = 8'($urandom_range(255));
                    req.insert(req.size(), (v == hrp_pkg::CH_CR) ? 8'h78 : v);
                end
                add_text(req, "\r\n");
            end
            case ($urandom_range(9))
                6, 7: req = req[0:$urandom_range(req.size() - 1)];
                8: req[$urandom_range(req.size() - 1)] = 8'($urandom_range(255));
                9:
                begin
                    req.delete();
                    repeat ($urandom_range(1, 8))
                        req.insert(req.size(), 8'($urandom_range(255)));
                end
                default: ;
            endcase
            send_bytes(req);
        end
    endtask

    initial
    begin : result_sink
        int unsigned      hold;
        hrp_pkg::result_t want;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected beat: kind %0d data %02h last %0b",
                                           kind, data, last_of_run));
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind || data !== want.data || last_of_run !== want.last)
                        note_failure($sformatf(
                            "beat mismatch: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
                            want.kind, want.data, want.last, kind, data, last_of_run));
                end
                hold = $urandom_range(sink_max_gap);
                if (hold > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("http_request_head_parser_top regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        in_byte = 8'h00;
        final_byte = 1'b0;
        reset_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_line();
        test_header_block();
        test_violations();
        test_random_requests();
        byte_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("http_request_head_parser_top regression: pass");
        else
            $display("http_request_head_parser_top regression: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/hrp_pkg.sv
sv/hrp_parser.sv
sv/hrp_result_queue.sv
sv/http_request_head_parser_top.sv
sim/testbench.sv
